### rtl/ces_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_pkg: shared types and constants of the contour edge splitter
// Side codes, register indexes, reset values and the segment record that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package ces_pkg;

  // Longest contour that is tracked exactly; beyond it the position saturates.
  localparam int MAX_POINTS = 4096;

  localparam int XY_W    = 12;
  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int MARG_W  = 8;
  localparam int CFG_W   = 12;
  localparam int CFGI_W  = 2;
  localparam int QDEPTH  = 4;

  typedef logic [1:0] side_t;
  localparam side_t SIDE_TOP    = 2'd0;
  localparam side_t SIDE_BOTTOM = 2'd1;
  localparam side_t SIDE_LEFT   = 2'd2;
  localparam side_t SIDE_RIGHT  = 2'd3;

  typedef logic [CFGI_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_FRAME_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_EDGE_MARGIN  = 2'd2;
  localparam cfg_idx_t CFG_MIN_POINTS   = 2'd3;

  localparam logic [XY_W-1:0]   RST_FRAME_WIDTH  = 12'd640;
  localparam logic [XY_W-1:0]   RST_FRAME_HEIGHT = 12'd480;
  localparam logic [MARG_W-1:0] RST_EDGE_MARGIN  = 8'd4;
  localparam logic [CFG_W-1:0]  RST_MIN_POINTS   = 12'd4;

  typedef struct packed {
    logic [IDX_W-1:0] start_index;
    logic [CNT_W-1:0] point_count;
    side_t            from_side;
    side_t            to_side;
  } seg_t;

  // All segments caused by one point; seg0 is always present, seg1 optional.
  typedef struct packed {
    logic two;
    seg_t seg0;
    seg_t seg1;
  } rec_t;

endpackage : ces_pkg
`default_nettype wire

### rtl/ces_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_front: point classifier and run tracker
// Holds the configuration registers, labels each point against the margins,
// tracks interior runs and builds the segment record for each point.
// ----------------------------------------------------------------------------
module ces_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire  ces_pkg::cfg_idx_t  cfg_index,
  input  wire  [ces_pkg::CFG_W-1:0] cfg_data,
  input  wire                      in_valid,
  input  wire                      q_ready,
  input  wire  [ces_pkg::XY_W-1:0] in_x,
  input  wire  [ces_pkg::XY_W-1:0] in_y,
  input  wire                      in_last,
  output logic                     push,
  output ces_pkg::rec_t            push_rec
);
  import ces_pkg::*;

  localparam int CW   = CNT_W;
  localparam int IW   = IDX_W;
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, MAXC}) ? MAXC : s[CW-1:0];
  endfunction

  logic [XY_W-1:0]   frame_width_r, frame_height_r;
  logic [MARG_W-1:0] edge_margin_r;
  logic [CFG_W-1:0]  min_points_r;

  logic [CW-1:0] position_r, lead_r, run_len_r;
  logic [IW-1:0] run_start_r;
  logic          seen_r, prev_b_r;
  side_t         first_side_r, prev_s_r, run_from_r;

  logic [CW-1:0] lead_n, run_len_n;
  logic [IW-1:0] run_start_n, idx;
  logic          seen_n, prev_b_n, border, accept, hit_a, hit_b;
  side_t         first_side_n, prev_s_n, run_from_n, side;
  logic [CW-1:0] cnt_a, cnt_b;
  logic [IW-1:0] start_b;
  side_t         from_b;
  seg_t          seg_a, seg_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      edge_margin_r  <= RST_EDGE_MARGIN;
      min_points_r   <= RST_MIN_POINTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        CFG_EDGE_MARGIN:  edge_margin_r  <= cfg_data[MARG_W-1:0];
        CFG_MIN_POINTS:   min_points_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // x > width - margin is tested as x + margin > width to stay unsigned.
  always_comb begin
    border = 1'b1;
    if ({4'b0, in_x} < {4'b0, edge_margin_r} + 16'd0) begin
      side = SIDE_LEFT;
    end else if ({1'b0, in_x} + {5'b0, edge_margin_r} > {1'b0, frame_width_r}) begin
      side = SIDE_RIGHT;
    end else if ({4'b0, in_y} < {4'b0, edge_margin_r} + 16'd0) begin
      side = SIDE_TOP;
    end else if ({1'b0, in_y} + {5'b0, edge_margin_r} > {1'b0, frame_height_r}) begin
      side = SIDE_BOTTOM;
    end else begin
      side   = SIDE_TOP;
      border = 1'b0;
    end
  end

  always_comb begin
    idx = (position_r < MAXC) ? position_r[IW-1:0] : IW'(MAX_POINTS - 1);

    seen_n       = seen_r;
    first_side_n = first_side_r;
    lead_n       = lead_r;
    prev_b_n     = prev_b_r;
    prev_s_n     = prev_s_r;
    run_start_n  = run_start_r;
    run_len_n    = run_len_r;
    run_from_n   = run_from_r;
    cnt_a        = sat_add(run_len_r, ONE);
    hit_a        = 1'b0;

    if (!seen_r) begin
      if (border) begin
        seen_n       = 1'b1;
        first_side_n = side;
        prev_b_n     = 1'b1;
        prev_s_n     = side;
      end else begin
        lead_n = sat_add(lead_r, ONE);
      end
    end else begin
      if (!prev_b_r && border) begin
        hit_a = (CMPW'(cnt_a) > CMPW'(min_points_r)) && (run_from_r != side);
      end else if (prev_b_r && !border) begin
        run_start_n = idx;
        run_len_n   = ONE;
        run_from_n  = prev_s_r;
      end else if (!prev_b_r && !border) begin
        run_len_n = sat_add(run_len_r, ONE);
      end
      prev_b_n = border;
      prev_s_n = side;
    end

    // Closing the wrap: the leading interior points join the open run, or
    // form a run of their own that leaves the last border side.
    if (!prev_b_n) begin
      cnt_b   = sat_add(sat_add(run_len_n, lead_n), ONE);
      start_b = run_start_n;
      from_b  = run_from_n;
    end else begin
      cnt_b   = sat_add(lead_n, ONE);
      start_b = '0;
      from_b  = prev_s_n;
    end
    hit_b = in_last && seen_n && (!prev_b_n || (lead_n != '0)) &&
            (CMPW'(cnt_b) > CMPW'(min_points_r)) && (from_b != first_side_n);

    seg_a = '{start_index: IDX_W'(run_start_r), point_count: CNT_W'(cnt_a),
              from_side: run_from_r, to_side: side};
    seg_b = '{start_index: IDX_W'(start_b), point_count: CNT_W'(cnt_b),
              from_side: from_b, to_side: first_side_n};

    accept        = in_valid && q_ready;
    push          = accept && (hit_a || hit_b);
    push_rec.two  = hit_a && hit_b;
    push_rec.seg0 = hit_a ? seg_a : seg_b;
    push_rec.seg1 = seg_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last)) begin
      position_r   <= '0;
      seen_r       <= 1'b0;
      first_side_r <= SIDE_TOP;
      lead_r       <= '0;
      prev_b_r     <= 1'b0;
      prev_s_r     <= SIDE_TOP;
      run_start_r  <= '0;
      run_len_r    <= '0;
      run_from_r   <= SIDE_TOP;
    end else if (accept) begin
      position_r   <= sat_add(position_r, ONE);
      seen_r       <= seen_n;
      first_side_r <= first_side_n;
      lead_r       <= lead_n;
      prev_b_r     <= prev_b_n;
      prev_s_r     <= prev_s_n;
      run_start_r  <= run_start_n;
      run_len_r    <= run_len_n;
      run_from_r   <= run_from_n;
    end
  end

endmodule : ces_front
`default_nettype wire

### rtl/ces_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_back: segment queue and output stage
// Buffers segment records and hands their segments out one per transaction.
// ----------------------------------------------------------------------------
module ces_back (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  wire  ces_pkg::rec_t        push_rec,
  output logic                       q_ready,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [ces_pkg::IDX_W-1:0]  out_start_index,
  output logic [ces_pkg::CNT_W-1:0]  out_point_count,
  output ces_pkg::side_t             out_from_side,
  output ces_pkg::side_t             out_to_side,
  output logic                       out_end_of_step
);
  import ces_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int NW = $clog2(QDEPTH + 1);

  rec_t          q_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          sub_r, out_valid_r, eos_r;
  seg_t          seg_r;
  rec_t          head;
  logic          load, pop, eos;

  assign head    = q_r[rd_ptr_r];
  assign q_ready = (count_r != NW'(QDEPTH));
  assign load    = !out_valid_r || out_ready;
  assign eos     = sub_r || !head.two;
  assign pop     = load && (count_r != '0) && eos;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= PW'((32'(wr_ptr_r) + 1) % QDEPTH);
      if (pop)  rd_ptr_r <= PW'((32'(rd_ptr_r) + 1) % QDEPTH);
      count_r <= count_r + NW'(push) - NW'(pop);
      if (load) begin
        out_valid_r <= (count_r != '0);
        if (count_r != '0) sub_r <= !eos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && (count_r != '0)) begin
      seg_r <= sub_r ? head.seg1 : head.seg0;
      eos_r <= eos;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_start_index = seg_r.start_index;
  assign out_point_count = seg_r.point_count;
  assign out_from_side   = seg_r.from_side;
  assign out_to_side     = seg_r.to_side;
  assign out_end_of_step = eos_r;

endmodule : ces_back
`default_nettype wire

### rtl/contour_edge_split_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contour_edge_split_top: splits a closed contour into edge-to-edge segments
// Points of one contour come in order; each run of interior points that
// leaves one frame side and reaches another, and is long enough, comes out
// as a segment described by start index, point count and the two sides.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Carries
//  in_*      input      in_valid / in_ready    x, y, last flag of one point
//  out_*     output     out_valid / out_ready  one segment and end_of_step
//  cfg_*     input      cfg_we                 register index and write data
//
//  One point is taken per cycle while in_ready is high; the run tracker
//  in the front end updates all of its state in the cycle of the transaction.
//  At the earliest, out_valid rises at the clock edge after the one that
//  accepts the point causing the segment; the last point of a contour may
//  cause two segments, which leave one per cycle while out_ready is high.
//  A four-record queue parts the front end from the output register, so
//  in_ready falls only when that queue is full under a stalled output.
//  Synchronous reset restores the register defaults and clears the contour
//  state, the queue and the output register; there is no clearing pass.

module contour_edge_split_top (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  ces_pkg::cfg_idx_t     cfg_index,
  input  wire  [ces_pkg::CFG_W-1:0]   cfg_data,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [ces_pkg::XY_W-1:0]    in_x,
  input  wire  [ces_pkg::XY_W-1:0]    in_y,
  input  wire                         in_last,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [ces_pkg::IDX_W-1:0]   out_start_index,
  output logic [ces_pkg::CNT_W-1:0]   out_point_count,
  output ces_pkg::side_t              out_from_side,
  output ces_pkg::side_t              out_to_side,
  output logic                        out_end_of_step
);
  import ces_pkg::*;

  // Front end to queue: a record is pushed only for points that give a segment.
  logic push;
  rec_t push_rec;
  logic q_ready;

  // Accepting a point depends only on room in the queue, never on the output.
  assign in_ready = q_ready;

  ces_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .q_ready   (q_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_last   (in_last),
    .push      (push),
    .push_rec  (push_rec)
  );

  ces_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .push_rec        (push_rec),
    .q_ready         (q_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_start_index (out_start_index),
    .out_point_count (out_point_count),
    .out_from_side   (out_from_side),
    .out_to_side     (out_to_side),
    .out_end_of_step (out_end_of_step)
  );

endmodule : contour_edge_split_top
`default_nettype wire

### rtl/ces_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_checker: port-level checks of the contour edge splitter
// Watches the top-level ports and flags behaviour the block must never show.
// ----------------------------------------------------------------------------
module ces_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [ces_pkg::IDX_W-1:0]   out_start_index,
  input wire [ces_pkg::CNT_W-1:0]   out_point_count,
  input wire [1:0]                  out_from_side,
  input wire [1:0]                  out_to_side,
  input wire                        out_end_of_step
);
  import ces_pkg::*;

  // A stalled segment stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_index) &&
    $stable(out_point_count) && $stable(out_from_side) &&
    $stable(out_to_side) && $stable(out_end_of_step))
    else $error("segment changed while stalled");

  // Reset empties the output register and leaves the queue with room.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output or queue not cleared by reset");

  // A segment always holds its closing border point.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_count != '0)
    else $error("segment with zero points");

  // A segment always joins two different sides.
  a_sides_differ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_from_side != out_to_side)
    else $error("segment leaves and reaches the same side");

endmodule : ces_checker

bind contour_edge_split_top ces_checker u_ces_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_start_index (out_start_index),
  .out_point_count (out_point_count),
  .out_from_side   (out_from_side),
  .out_to_side     (out_to_side),
  .out_end_of_step (out_end_of_step)
);
`default_nettype wire

### verif/contour_edge_split_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_edge_split_checker: segment predictor and scoreboard
// Watches the configuration port and both channels of the contour edge
// splitter, predicts the segments of every accepted point transaction and
// compares each accepted segment, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module contour_edge_split_checker (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  ces_pkg::cfg_idx_t           cfg_index,
  input  wire  [ces_pkg::CFG_W-1:0]         cfg_data,
  input  wire                               in_valid,
  input  wire                               in_ready,
  input  wire  [ces_pkg::XY_W-1:0]          in_x,
  input  wire  [ces_pkg::XY_W-1:0]          in_y,
  input  wire                               in_last,
  input  wire                               out_valid,
  input  wire                               out_ready,
  input  wire  [ces_pkg::IDX_W-1:0]         out_start_index,
  input  wire  [ces_pkg::CNT_W-1:0]         out_point_count,
  input  wire  ces_pkg::side_t              out_from_side,
  input  wire  ces_pkg::side_t              out_to_side,
  input  wire                               out_end_of_step,
  output int                                mismatches,
  output int                                outstanding,
  output int                                segments_seen
);
  import ces_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] start_index;
    logic [CNT_W-1:0] point_count;
    side_t            from_side;
    side_t            to_side;
    logic             end_of_step;
  } segment_t;

  typedef struct packed {
    logic  border;
    side_t side;
  } label_t;

  segment_t segments_due[$];
  segment_t staged [0:1];
  int       staged_n;
  int       fail_total = 0;
  int       seen_total = 0;

  logic [XY_W-1:0]   width_reg;
  logic [XY_W-1:0]   height_reg;
  logic [MARG_W-1:0] margin_reg;
  logic [CFG_W-1:0]  min_points_reg;

  logic [CNT_W-1:0]  position;
  logic              seen_border;
  side_t             first_side;
  logic [CNT_W-1:0]  lead_count;
  logic              prev_border;
  side_t             prev_side;
  logic [IDX_W-1:0]  run_start;
  logic [CNT_W-1:0]  run_length;
  side_t             run_from;

  task automatic report_mismatch(input string msg);
    $display("[%0t] segment mismatch: %s", $time, msg);
    fail_total++;
  endtask

  function automatic logic [CNT_W-1:0] clamp_sum(input int a, input int b);
    int s;
    s = a + b;
    return CNT_W'((s > MAX_POINTS) ? MAX_POINTS : s);
  endfunction

  // Margin tests in the order left, right, top, bottom.
  function automatic label_t classify_point(input logic [XY_W-1:0] x,
                                            input logic [XY_W-1:0] y);
    label_t l;
    int     xi, yi, wi, hi, mi;
    xi = x;
    yi = y;
    wi = width_reg;
    hi = height_reg;
    mi = margin_reg;
    l.border = 1'b1;
    if (xi < mi) l.side = SIDE_LEFT;
    else if (xi > wi - mi) l.side = SIDE_RIGHT;
    else if (yi < mi) l.side = SIDE_TOP;
    else if (yi > hi - mi) l.side = SIDE_BOTTOM;
    else begin
      l.border = 1'b0;
      l.side   = SIDE_TOP;
    end
    return l;
  endfunction

  task automatic forget_contour();
    position    = '0;
    seen_border = 1'b0;
    first_side  = SIDE_TOP;
    lead_count  = '0;
    prev_border = 1'b0;
    prev_side   = SIDE_TOP;
    run_start   = '0;
    run_length  = '0;
    run_from    = SIDE_TOP;
  endtask

  task automatic stage_segment(input logic [IDX_W-1:0] start, input logic [CNT_W-1:0] count,
                               input side_t from, input side_t to);
    if (count > min_points_reg && from != to) begin
      staged[staged_n] = {start, count, from, to, 1'b0};
      staged_n++;
    end
  endtask

  task automatic split_point(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                             input logic last);
    logic [IDX_W-1:0] idx;
    label_t           lab;
    idx      = IDX_W'((position < MAX_POINTS) ? int'(position) : MAX_POINTS - 1);
    lab      = classify_point(x, y);
    staged_n = 0;

    if (!seen_border) begin
      if (lab.border) begin
        seen_border = 1'b1;
        first_side  = lab.side;
        prev_border = 1'b1;
        prev_side   = lab.side;
      end else begin
        lead_count = clamp_sum(lead_count, 1);
      end
    end else begin
      if (!prev_border && lab.border) begin
        stage_segment(run_start, clamp_sum(run_length, 1), run_from, lab.side);
      end else if (prev_border && !lab.border) begin
        run_start  = idx;
        run_length = CNT_W'(1);
        run_from   = prev_side;
      end else if (!prev_border && !lab.border) begin
        run_length = clamp_sum(run_length, 1);
      end
      prev_border = lab.border;
      prev_side   = lab.side;
    end

    position = clamp_sum(position, 1);

    // Closing the wrap: the points held before the first border point join
    // the open run, or form a run of their own from the last border side.
    if (last) begin
      if (seen_border) begin
        if (!prev_border)
          stage_segment(run_start, clamp_sum(clamp_sum(run_length, lead_count), 1),
                        run_from, first_side);
        else if (lead_count > 0)
          stage_segment('0, clamp_sum(lead_count, 1), prev_side, first_side);
      end
      forget_contour();
    end

    if (staged_n > 0) staged[staged_n-1].end_of_step = 1'b1;
    for (int i = 0; i < staged_n; i++) segments_due.insert(segments_due.size(), staged[i]);
  endtask

  task automatic check_segment();
    segment_t want;
    seen_total++;
    if (segments_due.size() == 0) begin
      report_mismatch($sformatf("unexpected segment start %0d count %0d sides %0d->%0d",
                                out_start_index, out_point_count, out_from_side, out_to_side));
    end else begin
      want = segments_due.pop_front();
      if (out_start_index !== want.start_index)
        report_mismatch($sformatf("start_index %0d, predicted %0d",
                                  out_start_index, want.start_index));
      if (out_point_count !== want.point_count)
        report_mismatch($sformatf("point_count %0d, predicted %0d",
                                  out_point_count, want.point_count));
      if (out_from_side !== want.from_side)
        report_mismatch($sformatf("from_side %0d, predicted %0d",
                                  out_from_side, want.from_side));
      if (out_to_side !== want.to_side)
        report_mismatch($sformatf("to_side %0d, predicted %0d", out_to_side, want.to_side));
      if (out_end_of_step !== want.end_of_step)
        report_mismatch($sformatf("end_of_step %0b, predicted %0b",
                                  out_end_of_step, want.end_of_step));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg      = RST_FRAME_WIDTH;
      height_reg     = RST_FRAME_HEIGHT;
      margin_reg     = RST_EDGE_MARGIN;
      min_points_reg = RST_MIN_POINTS;
      forget_contour();
      segments_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_reg      = cfg_data;
          CFG_FRAME_HEIGHT: height_reg     = cfg_data;
          CFG_EDGE_MARGIN:  margin_reg     = cfg_data[MARG_W-1:0];
          CFG_MIN_POINTS:   min_points_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) split_point(in_x, in_y, in_last);
      if (out_valid && out_ready) check_segment();
    end
    mismatches    <= fail_total;
    outstanding   <= segments_due.size();
    segments_seen <= seen_total;
  end

endmodule : contour_edge_split_checker

### verif/contour_edge_split_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_edge_split_top_tb: testbench of the contour edge splitter
// Feeds closed contours, mostly shaped from labelled border and interior
// points under a range of frame and margin settings, with some arbitrary
// noise contours; a checker beside the block predicts and compares segments.
// ----------------------------------------------------------------------------
module contour_edge_split_top_tb;
  import ces_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [XY_W-1:0]     in_x;
  logic [XY_W-1:0]     in_y;
  logic                in_last;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [IDX_W-1:0]    out_start_index;
  logic [CNT_W-1:0]    out_point_count;
  side_t               out_from_side;
  side_t               out_to_side;
  logic                out_end_of_step;

  int mismatches;
  int outstanding;
  int segments_seen;

  // Idle rates in percent of cycles for the point sender and segment receiver.
  int send_idle = 35;
  int recv_idle = 50;

  // Our own copy of the programmed settings, used only to shape coordinates and run lengths.
  int cur_w = 640;
  int cur_h = 480;
  int cur_m = 4;
  int cur_min = 4;

  int points_sent = 0;

  side_t side_pick [4] = '{SIDE_TOP, SIDE_BOTTOM, SIDE_LEFT, SIDE_RIGHT};

  contour_edge_split_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_start_index (out_start_index),
    .out_point_count (out_point_count),
    .out_from_side   (out_from_side),
    .out_to_side     (out_to_side),
    .out_end_of_step (out_end_of_step)
  );

  contour_edge_split_checker segment_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_start_index (out_start_index),
    .out_point_count (out_point_count),
    .out_from_side   (out_from_side),
    .out_to_side     (out_to_side),
    .out_end_of_step (out_end_of_step),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .segments_seen   (segments_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver decides afresh every cycle whether it will take a segment,
  // so stalls land on every phase of the output queue.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Generous ceiling on the whole run: the slowest correct run, with every
  // stall in place, needs a small fraction of it.
  initial begin
    #1000000;
    $display("contour_edge_split_top_tb NOT OK");
    $finish;
  end

  // Offers one point and holds it until the transaction completes. The
  // sender idles cycle by cycle at the current rate before each offer.
  task automatic send_point(input int px, input int py, input bit lp);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x     <= XY_W'(px);
    in_y     <= XY_W'(py);
    in_last  <= lp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
  endtask

  // Picks coordinates that fall on the wanted side, or in the interior, under
  // the present settings. Where no such coordinate exists a random one is used
  // and the checker works out what it really is.
  task automatic send_shaped_point(input bit border, input side_t s, input bit lp);
    int lo_x, hi_x, lo_y, hi_y, ix, iy, px, py;
    lo_x = cur_m;
    hi_x = cur_w - cur_m;
    lo_y = cur_m;
    hi_y = cur_h - cur_m;
    ix = (lo_x <= hi_x) ? $urandom_range(hi_x, lo_x) : $urandom_range(4095);
    iy = (lo_y <= hi_y) ? $urandom_range(hi_y, lo_y) : $urandom_range(4095);
    px = ix;
    py = iy;
    if (border) begin
      case (s)
        SIDE_LEFT: begin
          px = (cur_m > 0) ? $urandom_range(cur_m - 1, 0) : $urandom_range(4095);
          py = $urandom_range(4095);
        end
        SIDE_RIGHT: begin
          px = (hi_x < 4095) ? $urandom_range(4095, (hi_x < 0) ? 0 : hi_x + 1)
                             : $urandom_range(4095);
          py = $urandom_range(4095);
        end
        SIDE_TOP: begin
          py = (cur_m > 0) ? $urandom_range(cur_m - 1, 0) : $urandom_range(4095);
        end
        default: begin
          py = (hi_y < 4095) ? $urandom_range(4095, (hi_y < 0) ? 0 : hi_y + 1)
                             : $urandom_range(4095);
        end
      endcase
    end
    send_point(px, py, lp);
  endtask

  // One contour. Most are well formed: an optional lead of interior points,
  // then runs that each start from one or two border points, then a closing
  // point of either kind. One in ten is a handful of arbitrary points.
  task automatic send_random_contour();
    int lead, runs, len, cap;
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++)
        send_point($urandom_range(4095), $urandom_range(4095), i == len - 1);
    end else begin
      cap  = (cur_min + 3 > 12) ? 12 : cur_min + 3;
      lead = $urandom_range(1) ? $urandom_range(6, 1) : 0;
      repeat (lead) send_shaped_point(1'b0, SIDE_TOP, 1'b0);
      runs = $urandom_range(4, 1);
      repeat (runs) begin
        repeat ($urandom_range(2, 1)) send_shaped_point(1'b1, side_pick[$urandom_range(3)], 1'b0);
        len = $urandom_range(cap, 0);
        repeat (len) send_shaped_point(1'b0, SIDE_TOP, 1'b0);
      end
      send_shaped_point($urandom_range(1), side_pick[$urandom_range(3)], 1'b1);
    end
  endtask

  // Stops offering and waits until every predicted segment has come out,
  // then gives points that cause no segment time to leave the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles; the spare upper bits of
  // the margin write carry random junk that the block has to ignore.
  task automatic program_regs(input int w, input int h, input int m, input int mp);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= CFG_W'(h);
    @(posedge clk);
    cfg_index <= CFG_EDGE_MARGIN;
    cfg_data  <= CFG_W'(($urandom_range(15) << MARG_W) | m[MARG_W-1:0]);
    @(posedge clk);
    cfg_index <= CFG_MIN_POINTS;
    cfg_data  <= CFG_W'(mp);
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_w   = w;
    cur_h   = h;
    cur_m   = m;
    cur_min = mp;
  endtask

  task automatic program_random();
    program_regs($urandom_range(4095, 64), $urandom_range(4095, 64),
                 $urandom_range(1) ? $urandom_range(255, 0) : $urandom_range(40, 0),
                 $urandom_range(8, 0));
  endtask

  initial begin
    int guard;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_x      <= '0;
    in_y      <= '0;
    in_last   <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed contours under the reset settings (640 x 480, margin 4,
    // more than 4 points needed).
    // A contour that never touches a border yields nothing.
    send_point(320, 240, 0);
    send_point(321, 241, 1);
    // Four leading interior points, a run from the left to the top, and a
    // wrap run from the top back to the left: two segments on the last point.
    repeat (4) send_point(320, 240, 0);
    send_point(0, 4095, 0);
    repeat (4) send_point(330, 250, 0);
    send_point(320, 0, 1);
    // A lead point, bottom then right borders back to back, and a run still
    // open on the last point that closes on the first border point.
    send_point(320, 240, 0);
    send_point(320, 4095, 0);
    send_point(4095, 0, 0);
    repeat (3) send_point(330, 250, 0);
    send_point(330, 250, 1);
    // A contour made of a single border point.
    send_point(0, 0, 1);

    // First phase: the sender idles a little, the receiver a lot.
    settle();
    program_regs(4095, 4095, 255, 0);
    repeat (4) send_random_contour();
    while (points_sent < 200) begin
      settle();
      program_random();
      repeat (4) send_random_contour();
    end

    // Second phase: the rates are swapped, and the smallest frame is tried.
    settle();
    send_idle = 50;
    recv_idle = 35;
    program_regs(1, 1, 0, 4095);
    repeat (3) send_random_contour();
    settle();
    program_regs(640, 480, 255, 1);
    repeat (3) send_random_contour();
    while (points_sent < 400) begin
      settle();
      program_random();
      repeat (4) send_random_contour();
    end

    // Third phase: no idling on either side.
    settle();
    send_idle = 0;
    recv_idle = 0;
    while (points_sent < 530) begin
      settle();
      program_random();
      repeat (4) send_random_contour();
    end

    // Wind down: wait for what is still expected, bounded, then a short
    // tail so that any stray segment is caught by the checker.
    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("contour_edge_split_top_tb OK");
    else
      $display("contour_edge_split_top_tb NOT OK");
    $finish;
  end

endmodule : contour_edge_split_top_tb
